>>> rtl/qo_pkg.sv
// ----------------------------------------------------------------------------
// qo_pkg: shared types and constants for the quadrature odometry block
// Step table, window record, configuration indexes and reset values.
// ----------------------------------------------------------------------------
package qo_pkg;

    localparam int CNT_W     = 32;                  // position and result width
    localparam int EL_W      = 17;                  // elapsed millisecond count
    localparam int WIN_W     = 16;                  // window_ms register
    localparam int CFG_W     = 32;                  // widest register
    localparam int CFG_IDX_W = 2;
    localparam int AVG_LOG2  = 3;
    localparam int AVG_DEPTH = 1 << AVG_LOG2;       // rates in the moving average
    localparam int TOT_W     = CNT_W + AVG_LOG2;    // running sum of the ring
    localparam int NUM_W     = 41;                  // |count| * 1000 fits in 41 bits
    localparam int MS_PER_S  = 1000;

    localparam logic [EL_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MS = 2'd0,
        CFG_UM_Q16    = 2'd1,
        CFG_MRAD_Q16  = 2'd2
    } t_cfg_idx;

    localparam logic [WIN_W-1:0] WINDOW_MS_RST = 16'd100;
    localparam logic [CFG_W-1:0] UM_Q16_RST    = 32'd9289000;
    localparam logic [CFG_W-1:0] MRAD_Q16_RST  = 32'd285810;

    // Closed window handed from the front end to the arithmetic back end
    typedef struct packed {
        logic signed [CNT_W-1:0] count;
        logic [EL_W-1:0]         elapsed;
    } t_close;

    // x4 decode: index is {new pair, old pair}
    function automatic logic signed [2:0] step_of(input logic [3:0] idx);
        logic signed [2:0] s;
        case (idx)
            4'd0:    s = 3'sd0;
            4'd1:    s = 3'sd1;
            4'd2:    s = -3'sd1;
            4'd3:    s = 3'sd2;
            4'd4:    s = -3'sd1;
            4'd5:    s = 3'sd0;
            4'd6:    s = -3'sd2;
            4'd7:    s = 3'sd1;
            4'd8:    s = 3'sd1;
            4'd9:    s = -3'sd2;
            4'd10:   s = 3'sd0;
            4'd11:   s = -3'sd1;
            4'd12:   s = 3'sd2;
            4'd13:   s = -3'sd1;
            4'd14:   s = 3'sd1;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/qo_in_if.sv
// ----------------------------------------------------------------------------
// qo_in_if: pin sample channel
// One item is one sample of pins A and B with the millisecond strobe.
// ----------------------------------------------------------------------------
interface qo_in_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic ms_tick;

    modport source (output valid, output pin_a, output pin_b, output ms_tick, input ready);
    modport sink   (input valid, input pin_a, input pin_b, input ms_tick, output ready);
endinterface

>>> rtl/qo_out_if.sv
// ----------------------------------------------------------------------------
// qo_out_if: odometry result channel
// One item per closed window: count, distance, angular rate and speed.
// ----------------------------------------------------------------------------
interface qo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] window_counts;
    logic signed [31:0] distance_um;
    logic signed [31:0] omega_mrad_s;
    logic signed [31:0] speed_um_s;

    modport source (output valid, output window_counts, output distance_um,
                    output omega_mrad_s, output speed_um_s, input ready);
    modport sink   (input valid, input window_counts, input distance_um,
                    input omega_mrad_s, input speed_um_s, output ready);
endinterface

>>> rtl/qo_front.sv
// ----------------------------------------------------------------------------
// qo_front: quadrature decode and window timing
// Takes one pin sample per cycle unless the queue is full, steps the
// position count and queues a record when the millisecond window closes.
// ----------------------------------------------------------------------------
module qo_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    qo_in_if.sink                       in_ch,
    input  logic [qo_pkg::WIN_W-1:0]    i_window_ms,
    input  logic                        i_q_full,
    output logic                        o_push,
    output qo_pkg::t_close              o_push_data
);

    logic [1:0]                     r_pair;
    logic                           r_primed;
    logic [qo_pkg::CNT_W-1:0]       r_pos;
    logic [qo_pkg::EL_W-1:0]        r_elapsed;

    logic [1:0]                     now_pair;
    logic signed [2:0]              step;
    logic [qo_pkg::CNT_W-1:0]       n_pos;
    logic [qo_pkg::EL_W-1:0]        n_elapsed;
    logic                           accept;
    logic                           close;

    // Any accepted sample may close a window, so take items only with room queued
    assign in_ch.ready = !i_q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb begin
        now_pair = {in_ch.pin_b, in_ch.pin_a};
        step     = qo_pkg::step_of({now_pair, r_pair});
        n_pos    = r_primed ? r_pos + {{(qo_pkg::CNT_W-3){step[2]}}, step} : r_pos;
        if (in_ch.ms_tick && r_elapsed != qo_pkg::ELAPSED_MAX) begin
            n_elapsed = r_elapsed + 1'b1;
        end else begin
            n_elapsed = r_elapsed;
        end
        close = n_elapsed > {1'b0, i_window_ms};
    end

    assign o_push              = accept && close;
    assign o_push_data.count   = n_pos;
    assign o_push_data.elapsed = n_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair    <= '0;
            r_primed  <= 1'b0;
            r_pos     <= '0;
            r_elapsed <= '0;
        end else if (accept) begin
            r_pair   <= now_pair;
            r_primed <= 1'b1;
            if (close) begin
                r_pos     <= '0;
                r_elapsed <= '0;
            end else begin
                r_pos     <= n_pos;
                r_elapsed <= n_elapsed;
            end
        end
    end

endmodule

>>> rtl/qo_queue.sv
// ----------------------------------------------------------------------------
// qo_queue: two-entry queue of closed windows
// Decouples the per-sample front end from the multi-cycle back end.
// ----------------------------------------------------------------------------
module qo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qo_pkg::t_close  i_wdata,
    output logic            o_full,
    output logic            o_valid,
    output qo_pkg::t_close  o_rdata,
    input  logic            i_pop
);

    qo_pkg::t_close r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> rtl/qo_back.sv
// ----------------------------------------------------------------------------
// qo_back: window arithmetic
// Count rate by bit-serial division, ring average, then three Q16.16
// scalings through one shared multiplier into the output register.
// ----------------------------------------------------------------------------
module qo_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  qo_pkg::t_close              i_q_data,
    output logic                        o_q_pop,
    input  logic [qo_pkg::CFG_W-1:0]    i_um_q16,
    input  logic [qo_pkg::CFG_W-1:0]    i_mrad_q16,
    qo_out_if.source                    out_ch
);

    localparam int CW    = qo_pkg::CNT_W;
    localparam int NW    = qo_pkg::NUM_W;
    localparam int EW    = qo_pkg::EL_W;
    localparam int TW    = qo_pkg::TOT_W;
    localparam int BIT_W = $clog2(NW);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCALE = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_SAT   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_AVG   = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                         r_state;
    logic signed [CW-1:0]           r_count;
    logic [CW-1:0]                  r_cmag;
    logic                           r_neg;
    logic [EW-1:0]                  r_div;
    logic [NW-1:0]                  r_num;      // dividend, shifts into quotient
    logic [EW-1:0]                  r_rem;
    logic [BIT_W-1:0]               r_bit;
    logic signed [CW-1:0]           r_rate;
    logic signed [CW-1:0]           r_ring [qo_pkg::AVG_DEPTH];
    logic [qo_pkg::AVG_LOG2-1:0]    r_slot;
    logic signed [TW-1:0]           r_total;
    logic [CW-1:0]                  r_amag;
    logic                           r_aneg;
    logic [1:0]                     r_mstep;
    logic [2*CW-1:0]                r_prod;
    logic [CW-1:0]                  r_dist;
    logic [CW-1:0]                  r_omega;
    logic [CW-1:0]                  r_speed;
    logic                           r_ovalid;
    logic [CW-1:0]                  r_o_count;
    logic [CW-1:0]                  r_o_dist;
    logic [CW-1:0]                  r_o_omega;
    logic [CW-1:0]                  r_o_speed;

    logic [EW:0]                    trial;
    logic                           qbit;
    logic [EW:0]                    trial_rem;
    logic signed [CW-1:0]           sat_rate;
    logic [TW-1:0]                  tot_mag;
    logic [CW-1:0]                  op_a;
    logic [CW-1:0]                  op_b;
    logic [CW-1:0]                  scaled;
    logic                           out_free;
    logic                           load_out;

    function automatic logic [CW-1:0] sat_q16(input logic [2*CW-1:0] prod, input logic neg);
        logic [2*CW-17:0] q;
        logic [CW-1:0]    r;
        q = prod[2*CW-1:16];
        if (neg) begin
            if (q > (2*CW-16)'(33'h1_0000_0000 >> 1)) begin
                r = {1'b1, {(CW-1){1'b0}}};
            end else begin
                r = CW'(-q);
            end
        end else begin
            if (q > (2*CW-16)'({1'b0, {(CW-1){1'b1}}})) begin
                r = {1'b0, {(CW-1){1'b1}}};
            end else begin
                r = q[CW-1:0];
            end
        end
        return r;
    endfunction

    always_comb begin
        // restoring division step
        trial     = {r_rem, r_num[NW-1]};
        qbit      = trial >= {1'b0, r_div};
        trial_rem = qbit ? trial - {1'b0, r_div} : trial;

        // quotient magnitude to signed 32-bit rate, saturating
        if (r_neg) begin
            if (r_num > NW'({1'b1, {(CW-1){1'b0}}})) begin
                sat_rate = {1'b1, {(CW-1){1'b0}}};
            end else begin
                sat_rate = CW'(-r_num);
            end
        end else begin
            if (r_num > NW'({1'b0, {(CW-1){1'b1}}})) begin
                sat_rate = {1'b0, {(CW-1){1'b1}}};
            end else begin
                sat_rate = r_num[CW-1:0];
            end
        end

        tot_mag = r_total[TW-1] ? TW'(-r_total) : TW'(r_total);

        case (r_mstep)
            2'd0:    begin op_a = r_cmag; op_b = i_um_q16;   end
            2'd1:    begin op_a = r_amag; op_b = i_mrad_q16; end
            default: begin op_a = r_amag; op_b = i_um_q16;   end
        endcase

        scaled = sat_q16(r_prod, (r_mstep == 2'd1) ? r_neg : r_aneg);
    end

    assign out_free = !r_ovalid || out_ch.ready;
    assign load_out = (r_state == S_DONE) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < qo_pkg::AVG_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_count <= i_q_data.count;
                        r_neg   <= i_q_data.count[CW-1];
                        r_cmag  <= i_q_data.count[CW-1] ? CW'(-i_q_data.count)
                                                        : CW'(i_q_data.count);
                        r_div   <= i_q_data.elapsed;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_num   <= NW'(r_cmag) * NW'(qo_pkg::MS_PER_S);
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= trial_rem[EW-1:0];
                    r_num <= {r_num[NW-2:0], qbit};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BIT_W'(NW-1)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_rate  <= sat_rate;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_total <= r_total - TW'(r_ring[r_slot]) + TW'(r_rate);
                    r_ring[r_slot] <= r_rate;
                    r_slot  <= r_slot + 1'b1;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    // average truncates toward zero: shift the magnitude
                    r_amag  <= tot_mag[qo_pkg::AVG_LOG2 +: CW];
                    r_aneg  <= r_total[TW-1];
                    r_mstep <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // product of step n is saturated while step n+1 multiplies
                    r_prod  <= op_a * op_b;
                    r_mstep <= r_mstep + 2'd1;
                    case (r_mstep)
                        2'd1:    r_dist  <= scaled;
                        2'd2:    r_omega <= scaled;
                        default: ;
                    endcase
                    if (r_mstep == 2'd3) begin
                        r_speed <= scaled;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_o_count <= r_count;
                        r_o_dist  <= r_dist;
                        r_o_omega <= r_omega;
                        r_o_speed <= r_speed;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid         = r_ovalid;
    assign out_ch.window_counts = r_o_count;
    assign out_ch.distance_um   = r_o_dist;
    assign out_ch.omega_mrad_s  = r_o_omega;
    assign out_ch.speed_um_s    = r_o_speed;

endmodule

>>> rtl/quadrature_odometry_top.sv
// ----------------------------------------------------------------------------
// quadrature_odometry_top: x4 quadrature decoder with windowed velocity
// Decodes one wheel's encoder pins and reports count, travel and averaged
// rates once per millisecond window.
// ----------------------------------------------------------------------------
// in_ch carries one pin sample per item (pin_a, pin_b, ms_tick); out_ch
// carries one result per closed window. A sample is taken every cycle while
// the two-entry window queue has room; samples that do not close a window
// produce nothing.
// A closing sample is queued for the back end, which divides count*1000 by
// the elapsed time one quotient bit per cycle, then runs three Q16.16
// scalings through one shared 32x32 multiplier. The back end takes a new
// window only once it is through with the last one; the queue absorbs two
// closes back to back.
// A stalled out_ch holds its result; the back end finishes the next window
// and waits, the queue fills and in_ch.ready drops until room is freed.
// Reset is synchronous, active low: pin state, counts, rate ring and queue
// clear and the registers return to window 100 ms and the default scales.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module quadrature_odometry_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qo_in_if.sink                           in_ch,
    qo_out_if.source                        out_ch,
    input  logic                            i_cfg_we,
    input  logic [qo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qo_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [qo_pkg::WIN_W-1:0]   r_window_ms;
    logic [qo_pkg::CFG_W-1:0]   r_um_q16;
    logic [qo_pkg::CFG_W-1:0]   r_mrad_q16;

    logic                       push;
    qo_pkg::t_close             push_data;
    logic                       q_full;
    logic                       q_valid;
    qo_pkg::t_close             q_data;
    logic                       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= qo_pkg::WINDOW_MS_RST;
            r_um_q16    <= qo_pkg::UM_Q16_RST;
            r_mrad_q16  <= qo_pkg::MRAD_Q16_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qo_pkg::CFG_WINDOW_MS: r_window_ms <= i_cfg_data[qo_pkg::WIN_W-1:0];
                qo_pkg::CFG_UM_Q16:    r_um_q16    <= i_cfg_data;
                qo_pkg::CFG_MRAD_Q16:  r_mrad_q16  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .i_window_ms (r_window_ms),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    qo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_data),
        .i_pop   (q_pop)
    );

    qo_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .i_um_q16   (r_um_q16),
        .i_mrad_q16 (r_mrad_q16),
        .out_ch     (out_ch)
    );

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the quadrature odometry block
// Feeds pin samples through the in channel and scores every window report
// against a cycle-free prediction of decode, rate ring and Q16.16 scaling,
// under varied register settings, random idling and back pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_SETTLE = 80;     // back end latency plus margin
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int STALL_LIMIT = 5000;   // cycles with nothing accepted
    localparam int SAT_RUN     = 50;     // samples per saturating window
    localparam int SAT_WINDOWS = 9;
    localparam int SAT_FWD     = 3;      // forward windows before the backward ones
    localparam int WIDE_RUN    = 50;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic ms_tick;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] counts;
        logic signed [31:0] distance;
        logic signed [31:0] omega;
        logic signed [31:0] speed;
    } t_report;

    typedef enum int {WALK_HOLD, WALK_FWD, WALK_BWD, WALK_NOISE} t_walk;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [qo_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [qo_pkg::CFG_W-1:0] cfg_data;

    qo_in_if  pins_ch ();
    qo_out_if odo_ch ();

    quadrature_odometry_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (pins_ch),
        .out_ch     (odo_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // x4 decode steps, indexed by {new pair, old pair}
    int step_lut [16] = '{0, 1, -1, 2, -1, 0, -2, 1, 1, -2, 0, -1, 2, -1, 1, 0};
    // every ordered pair of pin states once; the first entry only primes
    logic [1:0] pair_tour [17] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                                   2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

    // predicted block state and registers
    logic [qo_pkg::WIN_W-1:0]  win_ms;
    logic [31:0]               um_q16;
    logic [31:0]               mrad_q16;
    logic [1:0]                last_pair;
    bit                        primed;
    logic [qo_pkg::CNT_W-1:0]  pos_count;
    logic [qo_pkg::EL_W-1:0]   elapsed_ms;
    longint                    rate_ring [qo_pkg::AVG_DEPTH];
    int                        ring_slot;
    longint                    rate_total;

    t_sample samples_to_send[$];
    t_report reports_due[$];
    t_sample sample_on_bus;
    t_report got_report;
    t_report want_report;
    int      samples_queued;
    int      samples_taken;
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      quiet_cycles;
    bit      hold_go;
    logic    hold_on;
    logic [1:0] walk_pair;

    function automatic longint clamp_s32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // exact product with a Q16.16 factor, magnitude truncated, then clamped
    function automatic logic signed [31:0] q16_scale(input longint v, input logic [31:0] k);
        longint unsigned mag;
        longint unsigned prod;
        mag = (v < 0) ? -v : v;
        prod = (mag * k) >> 16;
        if (v < 0)
            return (prod > 64'h8000_0000) ? S32_MIN : -prod[31:0];
        return (prod > 64'h7FFF_FFFF) ? S32_MAX : prod[31:0];
    endfunction

    function automatic logic [1:0] gray_step(input logic [1:0] p, input bit up);
        logic [1:0] b;
        b = {p[1], p[1] ^ p[0]};
        b = up ? b + 2'd1 : b - 2'd1;
        return {b[1], b[1] ^ b[0]};
    endfunction

    task automatic odometry_predict(input t_sample s);
        logic [1:0] now_pair;
        longint cnt;
        longint el;
        longint rate;
        longint avg;
        t_report r;
        now_pair = {s.pin_b, s.pin_a};
        if (primed)
            pos_count = pos_count + step_lut[{now_pair, last_pair}];
        last_pair = now_pair;
        primed = 1'b1;
        if (s.ms_tick && elapsed_ms != qo_pkg::ELAPSED_MAX)
            elapsed_ms = elapsed_ms + 1'b1;
        if (elapsed_ms > win_ms) begin
            cnt = $signed(pos_count);
            el = elapsed_ms;
            pos_count = '0;
            elapsed_ms = '0;
            rate = clamp_s32((cnt * qo_pkg::MS_PER_S) / el);
            rate_total = rate_total - rate_ring[ring_slot] + rate;
            rate_ring[ring_slot] = rate;
            ring_slot = (ring_slot + 1) % qo_pkg::AVG_DEPTH;
            avg = rate_total / qo_pkg::AVG_DEPTH;
            r.counts = cnt[31:0];
            r.distance = q16_scale(cnt, um_q16);
            r.omega = q16_scale(avg, mrad_q16);
            r.speed = q16_scale(avg, um_q16);
            reports_due.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic push_sample(input logic [1:0] pair, input logic tick);
        samples_to_send.push_back('{pin_a: pair[0], pin_b: pair[1], ms_tick: tick});
        samples_queued++;
        walk_pair = pair;
    endtask

    // mostly legal quadrature runs, with holds and the odd illegal jump
    task automatic gen_walk(input int n, input int tick_pct);
        t_walk mode;
        int run_left;
        int r;
        logic [1:0] nxt;
        run_left = 0;
        mode = WALK_HOLD;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                r = $urandom_range(99);
                if (r < 10)
                    mode = WALK_HOLD;
                else if (r < 45)
                    mode = WALK_FWD;
                else if (r < 80)
                    mode = WALK_BWD;
                else
                    mode = WALK_NOISE;
                run_left = (mode == WALK_NOISE) ? $urandom_range(1, 4)
                                                : $urandom_range(1, 24);
            end
            run_left--;
            case (mode)
                WALK_FWD:   nxt = gray_step(walk_pair, 1'b1);
                WALK_BWD:   nxt = gray_step(walk_pair, 1'b0);
                WALK_NOISE: nxt = 2'($urandom_range(3));
                default:    nxt = walk_pair;
            endcase
            push_sample(nxt, $urandom_range(99) < tick_pct);
        end
    endtask

    task automatic write_reg(input qo_pkg::t_cfg_idx idx,
                             input logic [qo_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            qo_pkg::CFG_WINDOW_MS: win_ms = value[qo_pkg::WIN_W-1:0];
            qo_pkg::CFG_UM_Q16:    um_q16 = value;
            qo_pkg::CFG_MRAD_Q16:  mrad_q16 = value;
            default:               ;
        endcase
    endtask

    // all items taken, all reports in, then let the back end settle
    task automatic wait_idle();
        while (samples_taken != samples_queued || reports_due.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pins_ch.valid <= 1'b0;
        end else begin
            if (pins_ch.valid && pins_ch.ready) begin
                odometry_predict(sample_on_bus);
                samples_taken++;
            end
            if (!pins_ch.valid || pins_ch.ready) begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    sample_on_bus = samples_to_send.pop_front();
                    pins_ch.valid <= 1'b1;
                    pins_ch.pin_a <= sample_on_bus.pin_a;
                    pins_ch.pin_b <= sample_on_bus.pin_b;
                    pins_ch.ms_tick <= sample_on_bus.ms_tick;
                end else begin
                    pins_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and scoring
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            odo_ch.ready <= 1'b0;
        end else begin
            if (odo_ch.valid && odo_ch.ready) begin
                got_report = '{odo_ch.window_counts, odo_ch.distance_um,
                               odo_ch.omega_mrad_s, odo_ch.speed_um_s};
                if (reports_due.size() == 0) begin
                    flag_mismatch("report with none due", got_report.counts, 32'sd0);
                end else begin
                    want_report = reports_due.pop_front();
                    if (got_report.counts !== want_report.counts)
                        flag_mismatch("window_counts", got_report.counts, want_report.counts);
                    if (got_report.distance !== want_report.distance)
                        flag_mismatch("distance_um", got_report.distance,
                                      want_report.distance);
                    if (got_report.omega !== want_report.omega)
                        flag_mismatch("omega_mrad_s", got_report.omega, want_report.omega);
                    if (got_report.speed !== want_report.speed)
                        flag_mismatch("speed_um_s", got_report.speed, want_report.speed);
                end
            end
            odo_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long hold-off on the result side
    initial begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((pins_ch.valid && pins_ch.ready) || (odo_ch.valid && odo_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        pins_ch.valid = 1'b0;
        pins_ch.pin_a = 1'b0;
        pins_ch.pin_b = 1'b0;
        pins_ch.ms_tick = 1'b0;
        odo_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = qo_pkg::CFG_WINDOW_MS;
        cfg_data = '0;
        i_rst_n = 1'b0;
        hold_go = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        samples_queued = 0;
        samples_taken = 0;
        mismatches = 0;
        walk_pair = 2'd0;
        win_ms = qo_pkg::WINDOW_MS_RST;
        um_q16 = qo_pkg::UM_Q16_RST;
        mrad_q16 = qo_pkg::MRAD_Q16_RST;
        last_pair = 2'd0;
        primed = 1'b0;
        pos_count = '0;
        elapsed_ms = '0;
        ring_slot = 0;
        rate_total = 0;
        foreach (rate_ring[i]) rate_ring[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every pin transition, first sample ticks too
        foreach (pair_tour[i]) push_sample(pair_tour[i], 1'b1);
        gen_walk(100, 100);
        wait_idle();

        // lowered window: next item closes without a tick, then every tick closes
        write_reg(qo_pkg::CFG_WINDOW_MS, '0);
        write_reg(qo_pkg::CFG_UM_Q16, '0);
        write_reg(qo_pkg::CFG_MRAD_Q16, '1);
        push_sample(2'd3, 1'b0);
        push_sample(2'd0, 1'b1);
        push_sample(2'd3, 1'b1);
        push_sample(2'd1, 1'b0);
        push_sample(2'd2, 1'b1);
        push_sample(2'd2, 1'b1);
        push_sample(2'd0, 1'b1);
        wait_idle();

        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin
                    write_reg(qo_pkg::CFG_WINDOW_MS, 3);
                    write_reg(qo_pkg::CFG_UM_Q16, $urandom);
                    write_reg(qo_pkg::CFG_MRAD_Q16, '1);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_reg(qo_pkg::CFG_WINDOW_MS, $urandom_range(1, 8));
                    write_reg(qo_pkg::CFG_UM_Q16, '0);
                    write_reg(qo_pkg::CFG_MRAD_Q16, $urandom);
                    send_idle_pct = 70;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_reg(qo_pkg::CFG_WINDOW_MS, 1);
                    write_reg(qo_pkg::CFG_UM_Q16, '1);
                    write_reg(qo_pkg::CFG_MRAD_Q16, '0);
                    send_idle_pct = 0;
                    recv_stall_pct = 70;
                end
                default: begin
                    write_reg(qo_pkg::CFG_WINDOW_MS, $urandom_range(2, 6));
                    write_reg(qo_pkg::CFG_UM_Q16, $urandom);
                    write_reg(qo_pkg::CFG_MRAD_Q16, $urandom);
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            gen_walk(100, $urandom_range(30, 90));
            wait_idle();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // back pressure: a close every second item while results are held off;
        // the sender then waits for every report before moving on
        write_reg(qo_pkg::CFG_WINDOW_MS, 1);
        write_reg(qo_pkg::CFG_UM_Q16, $urandom);
        write_reg(qo_pkg::CFG_MRAD_Q16, $urandom);
        hold_go = 1'b1;
        gen_walk(150, 100);
        wait_idle();

        // big counts in one-tick windows: scaled averaged rates clamp both ways
        write_reg(qo_pkg::CFG_WINDOW_MS, '0);
        write_reg(qo_pkg::CFG_UM_Q16, '1);
        write_reg(qo_pkg::CFG_MRAD_Q16, '1);
        for (int w = 0; w < SAT_WINDOWS; w++)
            for (int i = 0; i < SAT_RUN; i++)
                push_sample((w < SAT_FWD) ? ((i % 2) ? 2'd3 : 2'd0)
                                          : ((i % 2) ? 2'd2 : 2'd1),
                            i == SAT_RUN - 1);
        wait_idle();

        // widest window: ticks on every item, nothing closes
        write_reg(qo_pkg::CFG_WINDOW_MS, '1);
        for (int i = 0; i < WIDE_RUN; i++)
            push_sample((i % 2) ? 2'd2 : 2'd1, 1'b1);
        wait_idle();

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
